FILE: hw/rtl/cbfp_pkg.sv
package cbfp_pkg;

    localparam logic [15:0] WORD_START    = 16'haa55;
    localparam logic [15:0] WORD_START_CC = 16'haa56;
    localparam logic [15:0] WORD_SWAPPED  = 16'h55aa;
    localparam logic [15:0] WORD_IDLE     = 16'hffff;
    localparam logic [7:0]  LIMIT_RESET   = 8'd30;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;
    localparam int          NUM_FIELDS    = 6;
    localparam logic [2:0]  FIELDS_NORMAL = 3'd5;
    localparam logic [2:0]  FIELDS_CC     = 3'd6;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_DROP = 3'd1,
        PH_CSUM = 3'd2,
        PH_DATA = 3'd3,
        PH_SEP  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_VALID     = 2'd0,
        KIND_CSUM_ERR  = 2'd1,
        KIND_FRAME_END = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        EMIT_NONE      = 2'd0,
        EMIT_BLOCK     = 2'd1,
        EMIT_FRAME_END = 2'd2
    } t_emit;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] signature;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] rotation;
        logic        is_cc;
        logic [7:0]  count;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result data;
    } t_queue_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: hw/rtl/cbfp_byte_if.sv
interface cbfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/cbfp_cfg_if.sv
interface cbfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] block_limit;

    modport source (output valid, output block_limit, input ready);
    modport sink   (input valid, input block_limit, output ready);
endinterface

FILE: hw/rtl/cbfp_result_if.sv
interface cbfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] object_signature;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] rotation;
    logic        is_color_code;
    logic [7:0]  frame_block_count;

    modport source (output valid, output result_kind, output object_signature,
                    output pos_x, output pos_y, output box_width, output box_height,
                    output rotation, output is_color_code, output frame_block_count,
                    input ready);
    modport sink   (input valid, input result_kind, input object_signature,
                    input pos_x, input pos_y, input box_width, input box_height,
                    input rotation, input is_color_code, input frame_block_count,
                    output ready);
endinterface

FILE: hw/rtl/cbfp_front.sv
module cbfp_front
    import cbfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_byte_valid,
    input  logic [7:0] i_byte,
    input  logic      i_cfg_write,
    input  logic [7:0] i_cfg_limit,
    output t_queue_wr o_queue_wr
);

    t_phase      r_phase, n_phase;
    logic        r_have_low, n_have_low;
    logic [7:0]  r_low_hold, n_low_hold;
    logic [15:0] r_prev_word, n_prev_word;
    logic        r_cc_mode, n_cc_mode;
    logic [2:0]  r_field_idx, n_field_idx;
    logic [15:0] r_expected_sum, n_expected_sum;
    logic [15:0] r_running_sum, n_running_sum;
    logic [7:0]  r_valid_count, n_valid_count;
    logic [7:0]  r_block_limit;
    logic [15:0] r_field_words [NUM_FIELDS];

    logic [15:0] w_word;
    logic [15:0] w_sum_next;
    logic [2:0]  w_idx_next;
    logic [2:0]  w_num_fields;
    logic [7:0]  w_limit;
    logic        w_is_start;
    logic        w_field_we;
    logic [15:0] w_fields [NUM_FIELDS];
    t_emit       w_emit;

    assign w_word       = {i_byte, r_low_hold};
    assign w_sum_next   = r_running_sum + w_word;
    assign w_idx_next   = r_field_idx + 3'd1;
    assign w_num_fields = r_cc_mode ? FIELDS_CC : FIELDS_NORMAL;
    assign w_limit      = (r_block_limit == 8'd0) ? 8'd1 : r_block_limit;
    assign w_is_start   = (w_word == WORD_START) || (w_word == WORD_START_CC);

    // Next-state logic; a transaction is processed only when a byte is accepted.
    always_comb begin
        n_phase        = r_phase;
        n_have_low     = r_have_low;
        n_low_hold     = r_low_hold;
        n_prev_word    = r_prev_word;
        n_cc_mode      = r_cc_mode;
        n_field_idx    = r_field_idx;
        n_expected_sum = r_expected_sum;
        n_running_sum  = r_running_sum;
        n_valid_count  = r_valid_count;
        w_field_we     = 1'b0;
        w_emit         = EMIT_NONE;
        if (i_byte_valid) begin
            if (r_phase == PH_DROP) begin
                n_phase = PH_HUNT;
            end else if (!r_have_low) begin
                n_low_hold = i_byte;
                n_have_low = 1'b1;
            end else begin
                n_have_low = 1'b0;
                case (r_phase)
                    PH_CSUM: begin
                        if (w_is_start) begin
                            // A start word here closes the frame but keeps parsing.
                            n_cc_mode     = (w_word == WORD_START_CC);
                            n_valid_count = 8'd0;
                            w_emit        = EMIT_FRAME_END;
                        end else if (w_word == 16'd0) begin
                            n_phase       = PH_HUNT;
                            n_prev_word   = WORD_IDLE;
                            n_valid_count = 8'd0;
                            w_emit        = EMIT_FRAME_END;
                        end else begin
                            n_expected_sum = w_word;
                            n_running_sum  = 16'd0;
                            n_field_idx    = 3'd0;
                            n_phase        = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        w_field_we    = 1'b1;
                        n_running_sum = w_sum_next;
                        n_field_idx   = w_idx_next;
                        if (w_idx_next >= w_num_fields) begin
                            if ((w_sum_next == r_expected_sum) && (r_valid_count != COUNT_MAX))
                            begin
                                n_valid_count = r_valid_count + 8'd1;
                            end
                            n_phase = PH_SEP;
                            w_emit  = EMIT_BLOCK;
                        end
                    end
                    PH_SEP: begin
                        if (w_is_start && (r_valid_count < w_limit)) begin
                            n_cc_mode = (w_word == WORD_START_CC);
                            n_phase   = PH_CSUM;
                        end else begin
                            if (w_is_start) begin
                                n_cc_mode = (w_word == WORD_START_CC);
                            end
                            n_phase       = PH_HUNT;
                            n_prev_word   = WORD_IDLE;
                            n_valid_count = 8'd0;
                            w_emit        = EMIT_FRAME_END;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        if ((w_word == 16'd0) && (r_prev_word == 16'd0)) begin
                            n_prev_word = WORD_IDLE;
                        end else if ((w_word == WORD_START) && (r_prev_word == WORD_START))
                        begin
                            n_cc_mode     = 1'b0;
                            n_valid_count = 8'd0;
                            n_phase       = PH_CSUM;
                        end else if ((w_word == WORD_START_CC) &&
                                     (r_prev_word == WORD_START_CC)) begin
                            n_cc_mode     = 1'b1;
                            n_valid_count = 8'd0;
                            n_phase       = PH_CSUM;
                        end else begin
                            if (w_word == WORD_SWAPPED) begin
                                n_phase = PH_DROP;
                            end
                            n_prev_word = w_word;
                        end
                    end
                endcase
            end
        end
    end

    // The last data word of a block is forwarded around the field store.
    always_comb begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
            w_fields[k] = (w_field_we && (r_field_idx == 3'(k))) ? w_word : r_field_words[k];
        end
    end

    always_comb begin
        o_queue_wr      = '0;
        o_queue_wr.data.kind = KIND_FRAME_END;
        case (w_emit)
            EMIT_BLOCK: begin
                o_queue_wr.push            = 1'b1;
                o_queue_wr.data.kind       = (w_sum_next == r_expected_sum) ?
                                             KIND_VALID : KIND_CSUM_ERR;
                o_queue_wr.data.signature  = w_fields[0];
                o_queue_wr.data.pos_x      = w_fields[1];
                o_queue_wr.data.pos_y      = w_fields[2];
                o_queue_wr.data.box_width  = w_fields[3];
                o_queue_wr.data.box_height = w_fields[4];
                o_queue_wr.data.rotation   = r_cc_mode ? w_fields[5] : 16'd0;
                o_queue_wr.data.is_cc      = r_cc_mode;
                o_queue_wr.data.count      = n_valid_count;
            end
            EMIT_FRAME_END: begin
                o_queue_wr.push       = 1'b1;
                o_queue_wr.data.count = r_valid_count;
            end
            default: begin
                o_queue_wr.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_have_low     <= 1'b0;
            r_low_hold     <= 8'd0;
            r_prev_word    <= WORD_IDLE;
            r_cc_mode      <= 1'b0;
            r_field_idx    <= 3'd0;
            r_expected_sum <= 16'd0;
            r_running_sum  <= 16'd0;
            r_valid_count  <= 8'd0;
            r_block_limit  <= LIMIT_RESET;
        end else begin
            r_phase        <= n_phase;
            r_have_low     <= n_have_low;
            r_low_hold     <= n_low_hold;
            r_prev_word    <= n_prev_word;
            r_cc_mode      <= n_cc_mode;
            r_field_idx    <= n_field_idx;
            r_expected_sum <= n_expected_sum;
            r_running_sum  <= n_running_sum;
            r_valid_count  <= n_valid_count;
            if (i_cfg_write) begin
                r_block_limit <= i_cfg_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_field_we) begin
            r_field_words[r_field_idx] <= w_word;
        end
    end

endmodule

FILE: hw/rtl/cbfp_queue.sv
module cbfp_queue
    import cbfp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_wr     i_queue_wr,
    input  logic          i_pop,
    output t_queue_status o_status,
    output t_result       o_head
);

    t_result    r_entries [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_do_pop;

    assign w_do_pop        = i_pop && (r_count != 2'd0);
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);
    assign o_head          = r_entries[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_queue_wr.push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (w_do_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        case ({i_queue_wr.push, w_do_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_queue_wr.push) begin
            r_entries[r_wr_ptr] <= i_queue_wr.data;
        end
    end

endmodule

FILE: hw/rtl/camera_block_frame_parser.sv
// Frame parser for the block protocol of an object-tracking camera.
// i_rx carries received serial bytes, low byte of each word first. A byte is
// taken in every cycle in which i_rx.valid and i_rx.ready are high.
// i_cfg writes the block limit (most valid blocks per frame); it is always
// ready and should be written only while the parser is idle.
// o_res carries one result per transaction: a valid block, a block with a
// checksum error, or a frame end with the count of valid blocks.
// Throughput is one byte per cycle while the queue is not full; the front
// parser updates its state on each accepted byte. A result is written into
// the queue in the cycle in which the byte that completes it is accepted.
// Results wait in a two-entry queue. When the receiver stalls, the queue fills
// and i_rx.ready drops until an entry is taken; no result is lost.
// Reset (synchronous, active low) empties the queue, returns the parser to
// hunting for sync and sets the block limit to 30.
module camera_block_frame_parser
    import cbfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cbfp_byte_if.sink            i_rx,
    cbfp_cfg_if.sink             i_cfg,
    cbfp_result_if.source        o_res
);

    t_queue_wr     w_queue_wr;
    t_queue_status w_status;
    t_result       w_head;
    logic          w_byte_accept;

    assign i_rx.ready    = !w_status.full;
    assign i_cfg.ready   = 1'b1;
    assign w_byte_accept = i_rx.valid && !w_status.full;

    cbfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_byte_accept),
        .i_byte       (i_rx.rx_byte),
        .i_cfg_write  (i_cfg.valid),
        .i_cfg_limit  (i_cfg.block_limit),
        .o_queue_wr   (w_queue_wr)
    );

    cbfp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_queue_wr (w_queue_wr),
        .i_pop      (o_res.ready),
        .o_status   (w_status),
        .o_head     (w_head)
    );

    assign o_res.valid             = !w_status.empty;
    assign o_res.result_kind       = w_head.kind;
    assign o_res.object_signature  = w_head.signature;
    assign o_res.pos_x             = w_head.pos_x;
    assign o_res.pos_y             = w_head.pos_y;
    assign o_res.box_width         = w_head.box_width;
    assign o_res.box_height        = w_head.box_height;
    assign o_res.rotation          = w_head.rotation;
    assign o_res.is_color_code     = w_head.is_cc;
    assign o_res.frame_block_count = w_head.count;

    // A result leaves the port only through a completed transaction.
    a_valid_drop_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_res.valid) |-> $past(o_res.ready))
        else $error("result dropped without a transaction");

    a_frame_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.result_kind == KIND_FRAME_END)) |->
        ((o_res.object_signature == 16'd0) && (o_res.rotation == 16'd0) &&
         (o_res.is_color_code == 1'b0)))
        else $error("frame end carries block fields");

    a_normal_block_no_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.is_color_code) |-> (o_res.rotation == 16'd0))
        else $error("normal block carries an angle");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_queue_wr.push |-> !w_status.full)
        else $error("result written into a full queue");

endmodule

FILE: dv/cbfp_frame_checker.sv
`timescale 1ns / 100ps

module cbfp_frame_checker
    import cbfp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cbfp_byte_if   i_rx,
    cbfp_cfg_if    i_cfg,
    cbfp_result_if i_res,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_good_blocks,
    output int     o_bad_blocks,
    output int     o_frame_ends
);

    // Parser state as the testbench tracks it.
    t_phase      phase;
    logic        have_low;
    logic [7:0]  low_hold;
    logic [15:0] prev_word;
    logic        cc_mode;
    logic [2:0]  field_idx;
    logic [15:0] csum_word;
    logic [15:0] sum_acc;
    logic [15:0] words [NUM_FIELDS];
    logic [7:0]  good_count;
    logic [7:0]  limit_reg;

    t_result     awaited_results [$];
    t_result     wanted;

    int fail_total;
    int good_total;
    int bad_total;
    int frame_total;

    assign o_fail_count  = fail_total;
    assign o_good_blocks = good_total;
    assign o_bad_blocks  = bad_total;
    assign o_frame_ends  = frame_total;

    initial begin
        fail_total  = 0;
        good_total  = 0;
        bad_total   = 0;
        frame_total = 0;
    end

    function automatic bit is_start(input logic [15:0] w);
        return (w == WORD_START) || (w == WORD_START_CC);
    endfunction

    task automatic enter_hunt();
        phase     = PH_HUNT;
        prev_word = WORD_IDLE;
    endtask

    task automatic close_frame();
        t_result r;
        r       = '0;
        r.kind  = KIND_FRAME_END;
        r.count = good_count;
        awaited_results.push_back(r);
        good_count = '0;
    endtask

    task automatic clear_parser();
        enter_hunt();
        have_low   = 1'b0;
        low_hold   = '0;
        cc_mode    = 1'b0;
        field_idx  = '0;
        csum_word  = '0;
        sum_acc    = '0;
        good_count = '0;
        limit_reg  = LIMIT_RESET;
        awaited_results.delete();
    endtask

    // Advances the tracked parser by one received byte and queues any result it causes.
    task automatic track_rx_byte(input logic [7:0] b);
        logic [15:0] w;
        logic [7:0]  eff_limit;
        logic [2:0]  need;
        t_result     r;
        if (phase == PH_DROP) begin
            phase = PH_HUNT;
        end else if (!have_low) begin
            low_hold = b;
            have_low = 1'b1;
        end else begin
            have_low = 1'b0;
            w = {b, low_hold};
            case (phase)
                PH_CSUM: begin
                    if (is_start(w)) begin
                        // A new start word here closes the frame but keeps parsing.
                        cc_mode = (w == WORD_START_CC);
                        close_frame();
                    end else if (w == 16'h0000) begin
                        enter_hunt();
                        close_frame();
                    end else begin
                        csum_word = w;
                        sum_acc   = '0;
                        field_idx = '0;
                        phase     = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (field_idx < NUM_FIELDS) begin
                        words[field_idx] = w;
                    end
                    sum_acc   = sum_acc + w;
                    field_idx = field_idx + 3'd1;
                    need      = cc_mode ? FIELDS_CC : FIELDS_NORMAL;
                    if (field_idx >= need) begin
                        r = '0;
                        if (sum_acc == csum_word) begin
                            r.kind = KIND_VALID;
                            if (good_count != COUNT_MAX) begin
                                good_count = good_count + 8'd1;
                            end
                        end else begin
                            r.kind = KIND_CSUM_ERR;
                        end
                        r.signature  = words[0];
                        r.pos_x      = words[1];
                        r.pos_y      = words[2];
                        r.box_width  = words[3];
                        r.box_height = words[4];
                        r.rotation   = cc_mode ? words[5] : 16'h0000;
                        r.is_cc      = cc_mode;
                        r.count      = good_count;
                        awaited_results.push_back(r);
                        phase = PH_SEP;
                    end
                end
                PH_SEP: begin
                    if (is_start(w)) begin
                        cc_mode   = (w == WORD_START_CC);
                        eff_limit = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
                        if (good_count >= eff_limit) begin
                            enter_hunt();
                            close_frame();
                        end else begin
                            phase = PH_CSUM;
                        end
                    end else begin
                        enter_hunt();
                        close_frame();
                    end
                end
                default: begin
                    phase = PH_HUNT;
                    if (w == 16'h0000 && prev_word == 16'h0000) begin
                        prev_word = WORD_IDLE;
                    end else if (w == WORD_START && prev_word == WORD_START) begin
                        cc_mode    = 1'b0;
                        good_count = '0;
                        phase      = PH_CSUM;
                    end else if (w == WORD_START_CC && prev_word == WORD_START_CC) begin
                        cc_mode    = 1'b1;
                        good_count = '0;
                        phase      = PH_CSUM;
                    end else begin
                        if (w == WORD_SWAPPED) begin
                            phase = PH_DROP;
                        end
                        prev_word = w;
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                limit_reg = i_cfg.block_limit;
            end
            if (i_rx.valid && i_rx.ready) begin
                track_rx_byte(i_rx.rx_byte);
            end
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result transaction with nothing outstanding, kind %0d count %0d",
                             $time, i_res.result_kind, i_res.frame_block_count);
                    fail_total++;
                end else begin
                    wanted = awaited_results.pop_front();
                    check_field("result_kind", {14'b0, wanted.kind}, {14'b0, i_res.result_kind});
                    check_field("object_signature", wanted.signature, i_res.object_signature);
                    check_field("pos_x", wanted.pos_x, i_res.pos_x);
                    check_field("pos_y", wanted.pos_y, i_res.pos_y);
                    check_field("box_width", wanted.box_width, i_res.box_width);
                    check_field("box_height", wanted.box_height, i_res.box_height);
                    check_field("rotation", wanted.rotation, i_res.rotation);
                    check_field("is_color_code", {15'b0, wanted.is_cc},
                                {15'b0, i_res.is_color_code});
                    check_field("frame_block_count", {8'b0, wanted.count},
                                {8'b0, i_res.frame_block_count});
                    case (wanted.kind)
                        KIND_VALID:    good_total++;
                        KIND_CSUM_ERR: bad_total++;
                        default:       frame_total++;
                    endcase
                end
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cbfp_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BYTES   = 205;

    typedef enum int {
        CLOSE_BAD_SEPARATOR,
        CLOSE_ZERO_CHECKSUM,
        CLOSE_START_AS_CHECKSUM
    } t_close;

    logic i_clk;
    logic i_rst_n;

    cbfp_byte_if   rx_if ();
    cbfp_cfg_if    cfg_if ();
    cbfp_result_if res_if ();

    int fail_count;
    int pending_results;
    int good_blocks;
    int bad_blocks;
    int frame_ends;

    int src_gap_pct;
    int snk_gap_pct;
    int bytes_sent;
    int cur_limit;

    camera_block_frame_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    cbfp_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (rx_if),
        .i_cfg         (cfg_if),
        .i_res         (res_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results),
        .o_good_blocks (good_blocks),
        .o_bad_blocks  (bad_blocks),
        .o_frame_ends  (frame_ends)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("camera_block_frame_parser regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_gap_pct);
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] start_of(input bit cc);
        return cc ? WORD_START_CC : WORD_START;
    endfunction

    function automatic logic [15:0] plain_word();
        logic [15:0] w;
        do w = rand_word(); while (w == WORD_START || w == WORD_START_CC);
        return w;
    endfunction

    // A checksum word with one of these values would end the frame instead.
    function automatic bit ends_frame_as_checksum(input logic [15:0] w);
        return (w == 16'h0000) || (w == WORD_START) || (w == WORD_START_CC);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_gap_pct) begin
            rx_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_gap_pct);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic push_word(input logic [15:0] w);
        push_byte(w[7:0]);
        push_byte(w[15:8]);
    endtask

    task automatic push_block(input bit cc, input bit good, input bit extremes);
        logic [15:0] fields [NUM_FIELDS];
        logic [15:0] sum;
        logic [15:0] csum;
        int          nf;
        nf  = cc ? 6 : 5;
        sum = '0;
        for (int i = 0; i < nf; i++) begin
            if (extremes) begin
                fields[i] = (i % 2 == 0) ? 16'hffff : 16'h0000;
            end else begin
                fields[i] = rand_word();
            end
            sum = sum + fields[i];
        end
        if (good) begin
            while (ends_frame_as_checksum(sum)) begin
                fields[0] = fields[0] + 16'd1;
                sum       = sum + 16'd1;
            end
            csum = sum;
        end else begin
            do csum = sum + 16'($urandom_range(1, 65535)); while (ends_frame_as_checksum(csum));
        end
        push_word(csum);
        for (int i = 0; i < nf; i++) begin
            push_word(fields[i]);
        end
    endtask

    // Sends a well-formed frame. The good-block count is mirrored here so that no
    // words are sent after the block limit has closed the frame.
    task automatic push_frame(input int nblk, input t_close close, input bit extremes);
        bit cc;
        bit good;
        int good_cnt;
        cc       = 1'($urandom_range(1));
        good_cnt = 0;
        push_word(start_of(cc));
        push_word(start_of(cc));
        for (int i = 0; i < nblk; i++) begin
            if (i > 0) begin
                cc = 1'($urandom_range(1));
                push_word(start_of(cc));
                if (good_cnt >= cur_limit) return;
            end
            good = extremes || ($urandom_range(99) < 80);
            push_block(cc, good, extremes);
            if (good) good_cnt++;
        end
        if (nblk == 0 && close == CLOSE_BAD_SEPARATOR) begin
            close = CLOSE_ZERO_CHECKSUM;
        end
        if (nblk > 0 && close != CLOSE_BAD_SEPARATOR) begin
            push_word(start_of(1'($urandom_range(1))));
            if (good_cnt >= cur_limit) return;
        end
        case (close)
            CLOSE_BAD_SEPARATOR: push_word(plain_word());
            CLOSE_ZERO_CHECKSUM: push_word(16'h0000);
            default: begin
                cc = 1'($urandom_range(1));
                push_word(start_of(cc));
                push_block(cc, 1'($urandom_range(1)), 1'b0);
                push_word(plain_word());
            end
        endcase
    endtask

    // Brings the parser back to hunting, word-aligned and with no start word
    // remembered, whatever state a noise burst left it in.
    task automatic flush_parser();
        repeat (18) push_byte(8'h01);
        push_byte(8'haa);
        push_byte(8'h55);
        push_byte(8'haa);
        push_word(16'h0101);
    endtask

    task automatic push_noise();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 24);
        case ($urandom_range(2))
            0: ;
            1: begin
                push_word(WORD_START);
                push_word(WORD_START);
            end
            default: begin
                push_byte(8'($urandom_range(255)));
                push_word(WORD_START_CC);
                push_word(WORD_START_CC);
            end
        endcase
        repeat (n) begin
            case ($urandom_range(7))
                0:       b = 8'h55;
                1:       b = 8'haa;
                2:       b = 8'h56;
                3:       b = 8'h00;
                default: b = 8'($urandom_range(255));
            endcase
            push_byte(b);
        end
        flush_parser();
    endtask

    task automatic settle();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_block_limit(input logic [7:0] v);
        cfg_if.valid       <= 1'b1;
        cfg_if.block_limit <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        cur_limit = int'(v);
    endtask

    initial begin
        int limits [NUM_PHASES];
        int target;
        bit paused;
        rx_if.valid        = 1'b0;
        rx_if.rx_byte      = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.block_limit = '0;
        res_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        src_gap_pct        = 29;
        snk_gap_pct        = 45;
        bytes_sent         = 0;
        cur_limit          = LIMIT_RESET;
        paused             = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Swapped word forces a dropped byte, two zero words restart the hunt,
        // then a frame of random kind with all-extreme fields closed by a zero checksum.
        push_byte(8'haa);
        push_byte(8'h55);
        push_byte(8'hff);
        push_word(16'h0000);
        push_word(16'h0000);
        push_frame(1, CLOSE_ZERO_CHECKSUM, 1'b1);

        limits[0] = 1;
        limits[1] = 255;
        limits[2] = $urandom_range(2, 5);
        limits[3] = 1;
        limits[4] = 255;
        limits[5] = $urandom_range(1, 255);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p / 2)
                0: begin
                    src_gap_pct = 29;
                    snk_gap_pct = 45;
                end
                1: begin
                    src_gap_pct = 45;
                    snk_gap_pct = 29;
                end
                default: begin
                    src_gap_pct = 0;
                    snk_gap_pct = 0;
                end
            endcase
            write_block_limit(8'(limits[p]));
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if (p == 2 && !paused && bytes_sent > target - PHASE_BYTES / 2) begin
                    // Hold the byte stream until every outstanding result is out.
                    settle();
                    paused = 1'b1;
                end
                if ($urandom_range(3) == 0) begin
                    push_noise();
                end else begin
                    push_frame($urandom_range(0, 6), t_close'($urandom_range(2)), 1'b0);
                end
            end
        end
        drain();

        $display("Sent %0d bytes under %0d block-limit settings and three idle mixes.",
                 bytes_sent, NUM_PHASES + 1);
        $display("Checked %0d good blocks, %0d checksum errors and %0d frame ends.",
                 good_blocks, bad_blocks, frame_ends);
        if (fail_count == 0) begin
            $display("camera_block_frame_parser regression: pass");
        end else begin
            $display("camera_block_frame_parser regression: fail");
        end
        $finish;
    end

endmodule
